FILE: hdl/bbt_pkg.sv
`timescale 1ns / 1ps
package bbt_pkg;

  localparam int FRAME_W   = 32;
  localparam int PERIOD_W  = 14;
  localparam int BPB_W     = 6;
  localparam int TPB_W     = 16;
  localparam int TEMPO_W   = 18;
  localparam int RATE_W    = 18;
  localparam int BAR_OUT_W = 16;
  localparam int TICK_W    = 16;
  localparam int BSTART_W  = 32;

  // sample rate * 60 fits in this many bits
  localparam int RATE60_W    = 24;
  localparam int SEC_PER_MIN = 60;

  // widest multiplier operand: bar length in beats times ticks per beat
  localparam int MUL_BITS = BPB_W + TPB_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_BPB   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd3;

  localparam logic [BPB_W-1:0]   BPB_RESET   = 6'd4;
  localparam logic [TPB_W-1:0]   TPB_RESET   = 16'd1920;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 18'd30720;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;

  localparam int TEMPO_FRAC_BITS_DEF = 8;
  localparam int BAR_WIDTH_DEF       = 16;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic CMD_ADVANCE  = 1'b0;
  localparam logic CMD_RELOCATE = 1'b1;

  // effective config, zero bpb, tpb and rate already forced to one; tempo passed as written
  typedef struct packed {
    logic [BPB_W-1:0]   bpb;
    logic [TPB_W-1:0]   tpb;
    logic [TEMPO_W-1:0] tempo;
    logic [RATE_W-1:0]  rate;
  } cfg_t;

endpackage

FILE: hdl/bbt_if.sv
`timescale 1ns / 1ps
interface bbt_item_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [bbt_pkg::FRAME_W-1:0]  frame_position;
  logic [bbt_pkg::PERIOD_W-1:0] period_frames;
  modport source(output valid, command, frame_position, period_frames, input ready);
  modport sink(input valid, command, frame_position, period_frames, output ready);
endinterface

interface bbt_result_if;
  logic                          valid;
  logic                          ready;
  logic [bbt_pkg::BAR_OUT_W-1:0] bar_number;
  logic [bbt_pkg::BPB_W-1:0]     beat_in_bar;
  logic [bbt_pkg::TICK_W-1:0]    tick_in_beat;
  logic [bbt_pkg::BSTART_W-1:0]  bar_first_tick;
  modport source(output valid, bar_number, beat_in_bar, tick_in_beat, bar_first_tick,
                 input ready);
  modport sink(input valid, bar_number, beat_in_bar, tick_in_beat, bar_first_tick,
               output ready);
endinterface

interface bbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bbt_pkg::CFG_IDX_W-1:0]  index;
  logic [bbt_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/bbt_regs.sv
`timescale 1ns / 1ps
module bbt_regs (
  input  logic           clk,
  input  logic           rst,
  bbt_cfg_if.sink        cfg,
  output bbt_pkg::cfg_t  cfg_q
);

  logic [bbt_pkg::BPB_W-1:0]   bpb;
  logic [bbt_pkg::TPB_W-1:0]   tpb;
  logic [bbt_pkg::TEMPO_W-1:0] tempo;
  logic [bbt_pkg::RATE_W-1:0]  rate;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpb   <= bbt_pkg::BPB_RESET;
      tpb   <= bbt_pkg::TPB_RESET;
      tempo <= bbt_pkg::TEMPO_RESET;
      rate  <= bbt_pkg::RATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bbt_pkg::REG_BPB:   bpb   <= cfg.data[bbt_pkg::BPB_W-1:0];
        bbt_pkg::REG_TPB:   tpb   <= cfg.data[bbt_pkg::TPB_W-1:0];
        bbt_pkg::REG_TEMPO: tempo <= cfg.data[bbt_pkg::TEMPO_W-1:0];
        bbt_pkg::REG_RATE:  rate  <= cfg.data[bbt_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_q.bpb   = (bpb == '0) ? bbt_pkg::BPB_W'(1) : bpb;
    cfg_q.tpb   = (tpb == '0) ? bbt_pkg::TPB_W'(1) : tpb;
    cfg_q.tempo = tempo;
    cfg_q.rate  = (rate == '0) ? bbt_pkg::RATE_W'(1) : rate;
  end

endmodule

FILE: hdl/bbt_alu.sv
`timescale 1ns / 1ps
module bbt_alu #(
  parameter int W = 50
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] q,
  output logic [W-1:0] r
);

  localparam int MB = bbt_pkg::MUL_BITS;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          op_r;
  logic [W-1:0]  acc;    // product, or dividend shifting out / quotient shifting in
  logic [W-1:0]  rem;
  logic [W-1:0]  opnd;   // multiplicand or divisor
  logic [MB-1:0] mplr;

  logic [W:0]    trial;
  logic [W+1:0]  lhs;
  logic [W+1:0]  rhs;
  logic [W+1:0]  sum;
  logic          cin;

  // single adder: shift-add for multiply, trial subtract for divide
  always_comb begin
    trial = {rem, acc[W-1]};
    if (op_r == bbt_pkg::OP_DIV) begin
      lhs = {1'b0, trial};
      rhs = ~{2'b00, opnd};
      cin = 1'b1;
    end else begin
      lhs = {2'b00, acc[W-2:0], 1'b0};
      rhs = {2'b00, (mplr[MB-1] ? opnd : {W{1'b0}})};
      cin = 1'b0;
    end
    sum = lhs + rhs + {{(W+1){1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= (op == bbt_pkg::OP_DIV) ? CW'(W) : CW'(MB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      if (op == bbt_pkg::OP_DIV) begin
        acc  <= a;
        rem  <= '0;
        opnd <= b;
      end else begin
        acc  <= '0;
        opnd <= a;
        mplr <= b[MB-1:0];
      end
    end else if (busy) begin
      if (op_r == bbt_pkg::OP_DIV) begin
        if (!sum[W+1]) begin
          rem <= sum[W-1:0];
          acc <= {acc[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          acc <= {acc[W-2:0], 1'b0};
        end
      end else begin
        acc  <= sum[W-1:0];
        mplr <= {mplr[MB-2:0], 1'b0};
      end
    end
  end

  assign q = acc;
  assign r = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("unit restarted while busy");
  a_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != CW'(1)) && !start |=> busy)
    else $error("unit stopped before its last step");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && (op_r == bbt_pkg::OP_DIV) |-> rem < opnd)
    else $error("remainder not below divisor");

endmodule

FILE: hdl/bar_beat_tick_position_counter.sv
`timescale 1ns / 1ps
// Flow: an accepted word runs through a sequence of steps on the shared unit to one result
//   word; an advance that carries no beat skips the beat and bar steps.
// Throughput: one word at a time, set by the bit-serial shared multiply/divide unit (one
//   bit per cycle, NW-bit divides); a stalled result word also holds off the next word.
// Reset (rst, synchronous): position to bar 1, beat 1, tick 0, bar start 0;
//   config registers to 4 beats, 1920 ticks, 120.0 bpm, 48000 frames/s.
module bar_beat_tick_position_counter #(
  parameter int TEMPO_FRAC_BITS = bbt_pkg::TEMPO_FRAC_BITS_DEF,
  parameter int BAR_WIDTH       = bbt_pkg::BAR_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bbt_cfg_if.sink       cfg,
  bbt_item_if.sink      item,
  bbt_result_if.source  result
);

  localparam int DIV_W  = bbt_pkg::RATE60_W + TEMPO_FRAC_BITS;
  localparam int PROD_W = bbt_pkg::FRAME_W + bbt_pkg::TEMPO_W;
  localparam int NW     = (DIV_W + bbt_pkg::TPB_W > PROD_W) ? DIV_W + bbt_pkg::TPB_W
                                                            : PROD_W;
  localparam int BPB_W  = bbt_pkg::BPB_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BT     = 4'd1;
  localparam logic [3:0] S_R_MULX = 4'd2;
  localparam logic [3:0] S_R_DIVX = 4'd3;
  localparam logic [3:0] S_R_DIVB = 4'd4;
  localparam logic [3:0] S_R_MULR = 4'd5;
  localparam logic [3:0] S_R_DIVR = 4'd6;
  localparam logic [3:0] S_R_MULS = 4'd7;
  localparam logic [3:0] S_A_MULP = 4'd8;
  localparam logic [3:0] S_A_MULT = 4'd9;
  localparam logic [3:0] S_A_DIVI = 4'd10;
  localparam logic [3:0] S_A_DIVC = 4'd11;
  localparam logic [3:0] S_A_DIVP = 4'd12;
  localparam logic [3:0] S_A_MULW = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  bbt_pkg::cfg_t cfgv;

  bbt_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfgv)
  );

  logic [3:0] state;
  logic       kick;
  logic       kick_next;
  logic       res_valid;

  logic [BAR_WIDTH-1:0]         bar_reg;
  logic [BPB_W-1:0]             beat_reg;
  logic [bbt_pkg::TICK_W-1:0]   tick_reg;
  logic [bbt_pkg::BSTART_W-1:0] bar_start_reg;

  logic                          cmd;
  logic [bbt_pkg::FRAME_W-1:0]   frame;
  logic [bbt_pkg::PERIOD_W-1:0]  period;
  logic [NW-1:0]                 d_reg;
  logic [bbt_pkg::MUL_BITS-1:0]  bt;
  logic [NW-1:0]                 w0;
  logic [NW-1:0]                 w1;
  logic                          wrap0;

  logic [bbt_pkg::BAR_OUT_W-1:0] out_bar;
  logic [BPB_W-1:0]              out_beat;
  logic [bbt_pkg::TICK_W-1:0]    out_tick;
  logic [bbt_pkg::BSTART_W-1:0]  out_bstart;

  logic          alu_op;
  logic [NW-1:0] alu_a;
  logic [NW-1:0] alu_b;
  logic          alu_done;
  logic [NW-1:0] alu_q;
  logic [NW-1:0] alu_r;

  logic            accept;
  logic            load_out;
  logic [BPB_W:0]  beat_inc;
  logic            wrap_now;
  logic [BPB_W-1:0] beat_base;
  logic [31:0]     bar_wide;

  assign accept   = item.valid && item.ready;
  assign load_out = (state == S_DONE) && (!res_valid || result.ready);
  assign beat_inc = {1'b0, beat_reg} + (BPB_W+1)'(1);
  assign wrap_now = beat_inc > {1'b0, cfgv.bpb};
  assign beat_base = wrap_now ? {BPB_W{1'b0}} : beat_reg;
  assign bar_wide = 32'(bar_reg);

  always_comb begin
    alu_op = bbt_pkg::OP_MUL;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_BT: begin
        alu_a = NW'(cfgv.bpb);
        alu_b = NW'(cfgv.tpb);
      end
      S_R_MULX: begin
        alu_a = NW'(frame);
        alu_b = NW'(cfgv.tempo);
      end
      S_R_DIVX, S_A_DIVI: begin
        alu_op = bbt_pkg::OP_DIV;
        alu_a  = w0;
        alu_b  = d_reg;
      end
      S_R_DIVB, S_A_DIVP: begin
        alu_op = bbt_pkg::OP_DIV;
        alu_a  = w0;
        alu_b  = NW'(cfgv.bpb);
      end
      S_R_MULR: begin
        alu_a = w1;
        alu_b = NW'(cfgv.tpb);
      end
      S_R_DIVR: begin
        alu_op = bbt_pkg::OP_DIV;
        alu_a  = w1;
        alu_b  = d_reg;
      end
      S_R_MULS, S_A_MULW: begin
        alu_a = w0;
        alu_b = NW'(bt);
      end
      S_A_MULP: begin
        alu_a = NW'(period);
        alu_b = NW'(cfgv.tpb);
      end
      S_A_MULT: begin
        alu_a = w0;
        alu_b = NW'(cfgv.tempo);
      end
      S_A_DIVC: begin
        alu_op = bbt_pkg::OP_DIV;
        alu_a  = w0;
        alu_b  = NW'(cfgv.tpb);
      end
      default: ;
    endcase
  end

  // next step of the shared unit is kicked in the cycle after the previous one signals done
  always_comb begin
    case (state)
      S_IDLE: kick_next = accept;
      S_BT, S_R_MULX, S_R_DIVX, S_R_DIVB, S_R_MULR, S_R_DIVR,
      S_A_MULP, S_A_MULT, S_A_DIVI, S_A_DIVP: kick_next = alu_done;
      S_A_DIVC: kick_next = alu_done && (alu_q != '0);
      default: kick_next = 1'b0;
    endcase
  end

  bbt_alu #(
    .W (NW)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (kick),
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .q     (alu_q),
    .r     (alu_r)
  );

  // sequencer and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kick          <= 1'b0;
      res_valid     <= 1'b0;
      bar_reg       <= BAR_WIDTH'(1);
      beat_reg      <= BPB_W'(1);
      tick_reg      <= '0;
      bar_start_reg <= '0;
    end else begin
      kick <= kick_next;
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_BT;
          end
        end
        S_BT: begin
          if (alu_done) begin
            state <= (cmd == bbt_pkg::CMD_RELOCATE) ? S_R_MULX : S_A_MULP;
          end
        end
        S_R_MULX: begin
          if (alu_done) begin
            state <= S_R_DIVX;
          end
        end
        S_R_DIVX: begin
          if (alu_done) begin
            state <= S_R_DIVB;
          end
        end
        S_R_DIVB: begin
          if (alu_done) begin
            beat_reg <= alu_r[BPB_W-1:0] + BPB_W'(1);
            bar_reg  <= alu_q[BAR_WIDTH-1:0] + BAR_WIDTH'(1);
            state    <= S_R_MULR;
          end
        end
        S_R_MULR: begin
          if (alu_done) begin
            state <= S_R_DIVR;
          end
        end
        S_R_DIVR: begin
          if (alu_done) begin
            tick_reg <= alu_q[bbt_pkg::TICK_W-1:0];
            state    <= S_R_MULS;
          end
        end
        S_R_MULS: begin
          if (alu_done) begin
            bar_start_reg <= alu_q[bbt_pkg::BSTART_W-1:0];
            state         <= S_DONE;
          end
        end
        S_A_MULP: begin
          if (alu_done) begin
            state <= S_A_MULT;
          end
        end
        S_A_MULT: begin
          if (alu_done) begin
            state <= S_A_DIVI;
          end
        end
        S_A_DIVI: begin
          if (alu_done) begin
            state <= S_A_DIVC;
          end
        end
        S_A_DIVC: begin
          if (alu_done) begin
            tick_reg <= alu_r[bbt_pkg::TICK_W-1:0];
            if (alu_q == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_A_DIVP;
            end
          end
        end
        S_A_DIVP: begin
          if (alu_done) begin
            beat_reg <= alu_r[BPB_W-1:0] + BPB_W'(1);
            state    <= S_A_MULW;
          end
        end
        S_A_MULW: begin
          if (alu_done) begin
            bar_reg       <= bar_reg + w0[BAR_WIDTH-1:0];
            bar_start_reg <= bar_start_reg + alu_q[bbt_pkg::BSTART_W-1:0];
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operands and intermediate values
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= item.command;
      frame  <= item.frame_position;
      period <= item.period_frames;
      d_reg  <= (NW'(cfgv.rate) * NW'(bbt_pkg::SEC_PER_MIN)) << TEMPO_FRAC_BITS;
    end
    if (alu_done) begin
      case (state)
        S_BT:     bt <= alu_q[bbt_pkg::MUL_BITS-1:0];
        S_R_MULX: w0 <= alu_q;
        S_R_DIVX: begin
          w0 <= alu_q;
          w1 <= alu_r;
        end
        S_R_DIVB: w0 <= alu_q;
        S_R_MULR: w1 <= alu_q;
        S_A_MULP: w0 <= alu_q;
        S_A_MULT: w0 <= alu_q;
        S_A_DIVI: w0 <= alu_q + NW'(tick_reg);
        S_A_DIVC: begin
          // position past beat one, counting the first carry separately
          w0    <= NW'(beat_base) + alu_q - NW'(1);
          wrap0 <= wrap_now;
        end
        S_A_DIVP: w0 <= alu_q + NW'(wrap0);
        default: ;
      endcase
    end
    if (load_out) begin
      out_bar    <= bar_wide[bbt_pkg::BAR_OUT_W-1:0];
      out_beat   <= beat_reg;
      out_tick   <= tick_reg;
      out_bstart <= bar_start_reg;
    end
  end

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = res_valid;
  assign result.bar_number     = out_bar;
  assign result.beat_in_bar    = out_beat;
  assign result.tick_in_beat   = out_tick;
  assign result.bar_first_tick = out_bstart;

  a_beat_nonzero: assert property (@(posedge clk) disable iff (rst)
    beat_reg != BPB_W'(0))
    else $error("beat dropped to zero");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> res_valid && (state == S_IDLE))
    else $error("finished word not presented");
  a_kick_after_done: assert property (@(posedge clk) disable iff (rst)
    kick |-> $past(accept) || $past(alu_done))
    else $error("unit started without a finished step");

endmodule
